// File: sv/npc_pkg.sv
`timescale 1ns / 1ps

package npc_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int CFG_ADDR_W   = 1;
  localparam int CFG_DATA_W   = 16;
  localparam int MAX_BYTES    = 6;
  localparam int SUM_W        = 26;
  localparam int RECIP_SHIFT  = 36;
  localparam int RECIP_W      = 27;
  localparam int PROD_W       = SUM_W + RECIP_W;

  localparam logic [9:0]          W_RED     = 10'd299;
  localparam logic [9:0]          W_GREEN   = 10'd587;
  localparam logic [9:0]          W_BLUE    = 10'd114;
  localparam logic [9:0]          LUMA_DIV  = 10'd1000;
  localparam logic [RECIP_W-1:0]  LUMA_RECIP = 27'd68719476;
  localparam logic [CFG_DATA_W-1:0] TWO_BYTE_MIN = 16'd256;
  localparam logic [CFG_DATA_W-1:0] MAX_VALUE_RST = 16'd255;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_MAX_VALUE = 1'b0,
    CFG_MODE      = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_RGB_TO_GREY = 2'd0,
    MODE_GREY_TO_MONO = 2'd1,
    MODE_PACK_MONO   = 2'd2,
    MODE_RAW         = 2'd3
  } conv_mode_t;

  typedef logic [SAMPLE_WIDTH-1:0] sample_t;

  typedef struct packed {
    conv_mode_t mode;
    sample_t    red;
    sample_t    green;
    sample_t    blue;
    logic       colour;
    logic       err;
    logic       two_byte;
    logic       emit;
    logic [7:0] pbyte;
  } side_t;

endpackage

// File: sv/netpbm_pixel_converter_top.sv
`timescale 1ns / 1ps

// channel   dir  tdata                          tuser        tlast
// in_       in   red_or_grey, green, blue       is_colour    row_end
// out_      out  out_byte                       range_error  last_of_run
// cfg_      in   write port: cfg_we, cfg_addr, cfg_wdata
//
// input register, four arithmetic stages and a byte serializer
// one request per cycle for mono and single-byte items while out_tready is
// high; a longer item holds the input while its bytes leave, one per cycle
// reset loads the default configuration, clears bit packing state and all valid flags
// the pipeline stalls only when its last stage holds an item and the
// serializer cannot load it

module netpbm_pixel_converter_top
  import npc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [47:0]            in_tdata,   // red_or_grey, green, blue
  input  logic                   in_tuser,   // is_colour
  input  logic                   in_tlast,   // row_end
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [7:0]             out_tdata,  // out_byte
  output logic                   out_tuser,  // range_error
  output logic                   out_tlast,  // last_of_run
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  logic [CFG_DATA_W-1:0] max_value_r;
  conv_mode_t            mode_r;

  logic    v0_r, v1_r, v2_r, v3_r, v4_r;
  logic    en;
  logic    ser_take;

  sample_t in_red_r, in_green_r, in_blue_r;
  logic    in_colour_r, in_row_end_r;

  // bit packing state
  logic [7:0] acc_r, acc_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       pend_r, pend_nxt;

  side_t side1_nxt, side1_r, side2_r, side3_r, side4_r;
  logic [24:0]       pr_r;
  logic [25:0]       pg_r;
  logic [22:0]       pb_r;
  logic [SUM_W-1:0]  sum2_r, sum3_r;
  logic [PROD_W-1:0] prod3_r;
  sample_t           luma4_r;

  logic [16:0] q0;
  logic [26:0] rem;
  sample_t     luma_fix;

  // serializer
  logic [MAX_BYTES-1:0][7:0] buf_r, list;
  logic [2:0]                scnt_r, list_cnt;
  logic                      serr_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_value_r <= MAX_VALUE_RST;
      mode_r      <= MODE_RGB_TO_GREY;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_MAX_VALUE: max_value_r <= cfg_wdata;
        CFG_MODE:      mode_r      <= conv_mode_t'(cfg_wdata[1:0]);
        default: ;
      endcase
    end
  end

  assign ser_take  = (scnt_r == 3'd0) || ((scnt_r == 3'd1) && out_tready);
  assign en        = !v4_r || ser_take;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_tvalid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_red_r     <= in_tdata[15:0];
      in_green_r   <= in_tdata[31:16];
      in_blue_r    <= in_tdata[47:32];
      in_colour_r  <= in_tuser;
      in_row_end_r <= in_tlast;
    end
  end

  // stage 1: error check, mono packing, weighted products
  always_comb begin
    logic [16:0] thr;
    logic        bit_in;
    logic        perr;
    logic [7:0]  acc_n;
    logic [3:0]  n;
    logic        big_any;
    logic        big_red;

    thr     = ({1'b0, max_value_r} + 17'd1) >> 1;
    big_red = in_red_r > max_value_r;
    big_any = big_red || (in_green_r > max_value_r) || (in_blue_r > max_value_r);
    bit_in  = 1'b0;
    perr    = 1'b0;
    acc_n   = '0;
    n       = '0;

    side1_nxt          = '0;
    side1_nxt.mode     = mode_r;
    side1_nxt.red      = in_red_r;
    side1_nxt.green    = in_green_r;
    side1_nxt.blue     = in_blue_r;
    side1_nxt.colour   = in_colour_r;
    side1_nxt.two_byte = max_value_r >= TWO_BYTE_MIN;

    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    pend_nxt = pend_r;

    case (mode_r)
      MODE_RGB_TO_GREY: begin
        side1_nxt.colour = 1'b0;
        side1_nxt.err    = big_any;
      end
      MODE_RAW: side1_nxt.err = in_colour_r ? big_any : big_red;
      default: begin
        if (mode_r == MODE_GREY_TO_MONO) begin
          bit_in = {1'b0, in_red_r} < thr;
          perr   = big_red;
        end else begin
          bit_in = in_red_r[0];
          perr   = in_red_r > sample_t'(1);
        end
        acc_n = {acc_r[6:0], bit_in};
        n     = {1'b0, cnt_r} + 4'd1;
        if (n == 4'd8 || in_row_end_r) begin
          side1_nxt.emit  = 1'b1;
          side1_nxt.pbyte = 8'(acc_n << (4'd8 - n));
          side1_nxt.err   = pend_r | perr;
          acc_nxt  = '0;
          cnt_nxt  = '0;
          pend_nxt = 1'b0;
        end else begin
          acc_nxt  = acc_n;
          cnt_nxt  = n[2:0];
          pend_nxt = pend_r | perr;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      cnt_r  <= '0;
      pend_r <= 1'b0;
    end else if (en && v0_r) begin
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
      pend_r <= pend_nxt;
    end
  end

  // luma pipeline: products, sum, reciprocal multiply, correction
  always_ff @(posedge clk) begin
    if (en) begin
      side1_r <= side1_nxt;
      pr_r    <= 25'(in_red_r * W_RED);
      pg_r    <= 26'(in_green_r * W_GREEN);
      pb_r    <= 23'(in_blue_r * W_BLUE);

      side2_r <= side1_r;
      sum2_r  <= SUM_W'({1'b0, pr_r}) + SUM_W'(pg_r) + SUM_W'({3'b0, pb_r});

      side3_r <= side2_r;
      sum3_r  <= sum2_r;
      prod3_r <= PROD_W'(sum2_r * LUMA_RECIP);

      side4_r <= side3_r;
      luma4_r <= luma_fix;
    end
  end

  always_comb begin
    q0  = prod3_r[PROD_W-1:RECIP_SHIFT];
    rem = {1'b0, sum3_r} - 27'(q0 * LUMA_DIV);
    if (rem >= 27'(LUMA_DIV)) begin
      luma_fix = sample_t'(q0 + 17'd1);
    end else begin
      luma_fix = sample_t'(q0);
    end
  end

  // byte list for the item leaving the last stage
  always_comb begin
    sample_t s0;
    s0       = (side4_r.mode == MODE_RGB_TO_GREY) ? luma4_r : side4_r.red;
    list     = '0;
    list_cnt = '0;
    case (side4_r.mode)
      MODE_GREY_TO_MONO, MODE_PACK_MONO: begin
        list[0]  = side4_r.pbyte;
        list_cnt = side4_r.emit ? 3'd1 : 3'd0;
      end
      default: begin
        if (side4_r.two_byte) begin
          list[0] = s0[15:8];
          list[1] = s0[7:0];
          list[2] = side4_r.green[15:8];
          list[3] = side4_r.green[7:0];
          list[4] = side4_r.blue[15:8];
          list[5] = side4_r.blue[7:0];
          list_cnt = side4_r.colour ? 3'd6 : 3'd2;
        end else begin
          list[0] = s0[7:0];
          list[1] = side4_r.green[7:0];
          list[2] = side4_r.blue[7:0];
          list_cnt = side4_r.colour ? 3'd3 : 3'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scnt_r <= '0;
    end else if (en && v4_r) begin
      scnt_r <= list_cnt;
    end else if (scnt_r != 3'd0 && out_tready) begin
      scnt_r <= scnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en && v4_r) begin
      buf_r  <= list;
      serr_r <= side4_r.err;
    end else if (scnt_r != 3'd0 && out_tready) begin
      buf_r <= {8'd0, buf_r[MAX_BYTES-1:1]};
    end
  end

  assign out_tvalid = scnt_r != 3'd0;
  assign out_tdata  = buf_r[0];
  assign out_tuser  = serr_r;
  assign out_tlast  = scnt_r == 3'd1;

endmodule
